[rtl/lpmd_pkg.sv]
// Package for the length-prefixed message deframer.
// Result beat type, header constants and queue sizing; no dependencies.
package lpmd_pkg;

    localparam logic [7:0] MAGIC_Z  = 8'h5A;
    localparam logic [7:0] MAGIC_H  = 8'h48;

    localparam logic [3:0] HDR_POS_MAGIC0 = 4'd0;
    localparam logic [3:0] HDR_POS_MAGIC1 = 4'd1;
    localparam logic [3:0] HDR_POS_MAGIC2 = 4'd2;
    localparam logic [3:0] HDR_POS_LEN0   = 4'd4;
    localparam logic [3:0] HDR_POS_LEN1   = 4'd5;
    localparam logic [3:0] HDR_POS_LEN2   = 4'd6;
    localparam logic [3:0] HDR_POS_LEN3   = 4'd7;
    localparam logic [3:0] HDR_POS_TYPEH  = 4'd8;
    localparam logic [3:0] HDR_POS_TYPEL  = 4'd9;
    localparam logic [3:0] HDR_POS_LAST   = 4'd15;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int PADDR_W = 3;
    localparam logic REG_HEARTBEAT_TYPE = 1'b0;

    typedef struct packed {
        logic [15:0] message_type;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        last_of_message;
        logic        magic_bad;
        logic        past_terminator;
    } t_result;

endpackage

[rtl/lpmd_if.sv]
// Valid/ready stream interfaces for the deframer: received bytes in, results out.
// Standalone; no package dependency.
interface lpmd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpmd_msg_if;
    logic        valid;
    logic        ready;
    logic [15:0] message_type;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        last_of_message;
    logic        magic_bad;
    logic        past_terminator;

    modport source (output valid, output message_type, output data_byte, output has_data,
                    output last_of_message, output magic_bad, output past_terminator,
                    input ready);
    modport sink   (input valid, input message_type, input data_byte, input has_data,
                    input last_of_message, input magic_bad, input past_terminator,
                    output ready);
endinterface

[rtl/length_prefixed_message_deframer_top.sv]
// Length-prefixed message deframer, top level: parser, result queue, output stage, APB register.
// Throughput: one rx byte per cycle unless stalled; a result is queued, then registered.
// Input stalls only when the 4-entry result queue is full; the output register decouples ready.
// Reset (i_rst_n, synchronous, active low) clears parser state, queue and heartbeat_type to 0.
// Depends on lpmd_pkg, lpmd_if, lpmd_front, lpmd_fifo, lpmd_back.
module length_prefixed_message_deframer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lpmd_byte_if.sink                      i_rx,
    lpmd_msg_if.source                     o_msg,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpmd_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import lpmd_pkg::*;

    logic [15:0] r_heartbeat_type;
    logic        front_push;
    t_result     front_result;
    logic        q_space;
    logic        q_nonempty;
    t_result     q_data;
    logic        back_pop;
    t_result     back_result;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HEARTBEAT_TYPE);
    assign prdata = (paddr[2] == REG_HEARTBEAT_TYPE) ? {16'd0, r_heartbeat_type} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heartbeat_type <= '0;
        end else if (cfg_wr) begin
            r_heartbeat_type <= pwdata[15:0];
        end
    end

    lpmd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_rx.valid),
        .i_byte           (i_rx.rx_byte),
        .i_space          (q_space),
        .i_heartbeat_type (r_heartbeat_type),
        .o_ready          (i_rx.ready),
        .o_push           (front_push),
        .o_result         (front_result)
    );

    lpmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (front_push),
        .i_data     (front_result),
        .i_pop      (back_pop),
        .o_space    (q_space),
        .o_nonempty (q_nonempty),
        .o_data     (q_data)
    );

    lpmd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (q_nonempty),
        .i_data     (q_data),
        .i_ready    (o_msg.ready),
        .o_pop      (back_pop),
        .o_valid    (o_msg.valid),
        .o_result   (back_result)
    );

    assign o_msg.message_type    = back_result.message_type;
    assign o_msg.data_byte       = back_result.data_byte;
    assign o_msg.has_data        = back_result.has_data;
    assign o_msg.last_of_message = back_result.last_of_message;
    assign o_msg.magic_bad       = back_result.magic_bad;
    assign o_msg.past_terminator = back_result.past_terminator;

endmodule

[rtl/lpmd_front.sv]
// Header parser and payload counter: takes one byte a beat, pushes result beats unless the type is the heartbeat type.
// Depends on lpmd_pkg.
module lpmd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_space,
    input  logic [15:0]       i_heartbeat_type,
    output logic              o_ready,
    output logic              o_push,
    output lpmd_pkg::t_result o_result
);
    import lpmd_pkg::*;

    logic [3:0]  r_hdr_pos,  n_hdr_pos;
    logic        r_in_pay,   n_in_pay;
    logic [31:0] r_remain,   n_remain;
    logic [15:0] r_type,     n_type;
    logic [31:0] r_len,      n_len;
    logic        r_magic_err, n_magic_err;
    logic        r_zero_seen, n_zero_seen;

    logic accept;
    logic silent;
    logic zero_now;
    logic last_byte;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;
    assign silent  = (r_type == i_heartbeat_type);
    assign zero_now  = r_zero_seen || (i_byte == 8'd0);
    assign last_byte = (r_remain == 32'd1);

    always_comb begin
        n_hdr_pos   = r_hdr_pos;
        n_in_pay    = r_in_pay;
        n_remain    = r_remain;
        n_type      = r_type;
        n_len       = r_len;
        n_magic_err = r_magic_err;
        n_zero_seen = r_zero_seen;
        o_push      = 1'b0;
        o_result    = '{message_type: r_type, data_byte: 8'd0, has_data: 1'b0,
                        last_of_message: 1'b1, magic_bad: r_magic_err,
                        past_terminator: 1'b0};
        if (accept) begin
            if (r_in_pay) begin
                n_zero_seen = zero_now;
                n_remain    = r_remain - 32'd1;
                o_push      = !silent;
                o_result    = '{message_type: r_type, data_byte: i_byte, has_data: 1'b1,
                                last_of_message: last_byte, magic_bad: r_magic_err,
                                past_terminator: zero_now};
                if (last_byte) begin
                    n_hdr_pos   = '0;
                    n_in_pay    = 1'b0;
                    n_remain    = '0;
                    n_len       = '0;
                    n_magic_err = 1'b0;
                    n_zero_seen = 1'b0;
                end
            end else begin
                unique case (r_hdr_pos)
                    HDR_POS_MAGIC0: begin
                        if (i_byte != MAGIC_Z) n_magic_err = 1'b1;
                    end
                    HDR_POS_MAGIC1, HDR_POS_MAGIC2: begin
                        if (i_byte != MAGIC_H) n_magic_err = 1'b1;
                    end
                    HDR_POS_LEN0, HDR_POS_LEN1, HDR_POS_LEN2, HDR_POS_LEN3: begin
                        n_len = {r_len[23:0], i_byte};
                    end
                    HDR_POS_TYPEH: begin
                        n_type = {i_byte, 8'd0};
                    end
                    HDR_POS_TYPEL: begin
                        n_type = {r_type[15:8], i_byte};
                    end
                    default: begin
                    end
                endcase
                if (r_hdr_pos != HDR_POS_LAST) begin
                    n_hdr_pos = r_hdr_pos + 4'd1;
                end else if (r_len != 32'd0) begin
                    n_hdr_pos   = '0;
                    n_in_pay    = 1'b1;
                    n_remain    = r_len;
                    n_len       = '0;
                    n_zero_seen = 1'b0;
                end else begin
                    // empty message
                    o_push      = !silent;
                    n_hdr_pos   = '0;
                    n_in_pay    = 1'b0;
                    n_remain    = '0;
                    n_len       = '0;
                    n_magic_err = 1'b0;
                    n_zero_seen = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos   <= '0;
            r_in_pay    <= 1'b0;
            r_remain    <= '0;
            r_type      <= '0;
            r_len       <= '0;
            r_magic_err <= 1'b0;
            r_zero_seen <= 1'b0;
        end else begin
            r_hdr_pos   <= n_hdr_pos;
            r_in_pay    <= n_in_pay;
            r_remain    <= n_remain;
            r_type      <= n_type;
            r_len       <= n_len;
            r_magic_err <= n_magic_err;
            r_zero_seen <= n_zero_seen;
        end
    end

endmodule

[rtl/lpmd_fifo.sv]
// Short result queue between parser and output stage.
// Depends on lpmd_pkg.
module lpmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpmd_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_space,
    output logic              o_nonempty,
    output lpmd_pkg::t_result o_data
);
    import lpmd_pkg::*;

    t_result           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]   r_count,  n_count;

    assign o_space    = (r_count != Q_CW'(Q_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_AW'(1);
        end
        priority if (i_push && !i_pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - Q_CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/lpmd_back.sv]
// Output register stage: drains the result queue onto the result channel.
// Depends on lpmd_pkg.
module lpmd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_nonempty,
    input  lpmd_pkg::t_result i_data,
    input  logic              i_ready,
    output logic              o_pop,
    output logic              o_valid,
    output lpmd_pkg::t_result o_result
);
    import lpmd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_data;

    assign o_pop    = i_nonempty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_data;

    always_comb begin
        n_valid = r_valid;
        priority if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule
